/* hw/rtl/text_mode_terminal_writer_core_macros.svh */
// Assertion helpers used by the terminal writer top level.
`ifndef TEXT_MODE_TERMINAL_WRITER_CORE_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_CORE_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define TMTW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Two conditions that must never be true together.
`define TMTW_ASSERT_EXCL(lbl, a, b, msg) \
    `TMTW_ASSERT_IMPL(lbl, a, !(b), msg)

`endif

/* hw/rtl/tmtw_pkg.sv */
`default_nettype none
package tmtw_pkg;

    localparam int CELL_IDX_W = 11;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_COL_W  = 7;
    localparam int CELL_W     = 16;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_WIPE  = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] CH_BLANK   = 8'h20;
    localparam logic [7:0] CLEAR_ATTR = 8'h07;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CR,
        OP_LF,
        OP_BS,
        OP_CHAR,
        OP_CLEAR,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t                kind;
        logic [7:0]              ch;
        logic [7:0]              attr;
        logic [CELL_IDX_W-1:0]   idx;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic init_busy;
        logic pop;
    } back_status_t;

endpackage
`default_nettype wire

/* hw/rtl/tmtw_front.sv */
`default_nettype none
module tmtw_front
    import tmtw_pkg::*;
(
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire q_status_t    q_stat,
    input  wire back_status_t back_stat,
    output logic              push,
    output op_t               op
);

    logic [7:0] ch;

    assign ch       = s_tdata[7:0];
    assign s_tready = !q_stat.full && !back_stat.init_busy;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        op.ch   = ch;
        op.attr = s_tdata[15:8];
        op.idx  = s_tdata[16 +: CELL_IDX_W];
        unique case (s_tuser)
            CMD_PUT: begin
                if (ch == CH_CR) begin
                    op.kind = OP_CR;
                end else if (ch == CH_LF) begin
                    op.kind = OP_LF;
                end else if (ch == CH_BS || ch == CH_DEL) begin
                    op.kind = OP_BS;
                end else begin
                    op.kind = OP_CHAR;
                end
            end
            CMD_WIPE:  op.kind = OP_CLEAR;
            CMD_READ:  op.kind = OP_READ;
            default:   op.kind = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/tmtw_fifo.sv */
`default_nettype none
module tmtw_fifo
    import tmtw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire op_t  push_data,
    input  wire logic pop,
    output op_t       pop_data,
    output q_status_t q_stat
);

    op_t        entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == 2'd2;
    assign q_stat.empty = count_reg == 2'd0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/tmtw_back.sv */
`default_nettype none
module tmtw_back
    import tmtw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire op_t    q_data,
    input  wire q_status_t q_stat,
    output back_status_t back_stat,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output logic [31:0] m_tdata
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int IDX_W  = (ADDR_W > CELL_IDX_W) ? ADDR_W : CELL_IDX_W;

    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_WRAP    = COL_W'(COLS);
    localparam logic [ADDR_W-1:0] LAST_COPY   = ADDR_W'(CELLS - COLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] CLEAR_CELL  = {CLEAR_ATTR, CH_BLANK};

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_POST
    } state_t;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    state_t             state_reg,    state_next;
    logic [ADDR_W-1:0]  cnt_reg,      cnt_next;
    logic [CELL_W-1:0]  fill_val_reg, fill_val_next;
    logic [ROW_W-1:0]   row_reg,      row_next;
    logic [COL_W-1:0]   col_reg,      col_next;
    logic [ADDR_W-1:0]  base_reg,     base_next;
    op_t                cur_reg,      cur_next;
    logic               init_reg,     init_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_ROW_W-1:0] out_row_reg,  out_row_next;
    logic [OUT_COL_W-1:0] out_col_reg,  out_col_next;
    logic [CELL_W-1:0]    out_data_reg, out_data_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               pop;
    logic               emit;
    logic [CELL_W-1:0]  emit_data;
    logic               in_range;

    assign in_range            = IDX_W'(q_data.idx) < IDX_W'(CELLS);
    assign pop                 = state_reg == S_IDLE && !init_reg && !q_stat.empty
                                 && (!out_valid_reg || m_tready);
    assign back_stat.pop       = pop;
    assign back_stat.init_busy = init_reg;
    assign m_tvalid            = out_valid_reg;
    assign m_tdata             = {4'd0, out_data_reg, out_col_reg, out_row_reg};

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        fill_val_next = fill_val_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        cur_next      = cur_reg;
        init_next     = init_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = fill_val_reg;
        mem_raddr     = ADDR_W'(cnt_reg + COLS);
        emit          = 1'b0;
        emit_data     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    cur_next = q_data;
                    case (q_data.kind)
                        OP_CR: begin
                            col_next = '0;
                            emit     = 1'b1;
                        end
                        OP_LF: begin
                            col_next = '0;
                            if (row_reg == LAST_ROW) begin
                                cnt_next      = '0;
                                fill_val_next = {q_data.attr, CH_BLANK};
                                state_next    = S_SCR_RD;
                            end else begin
                                row_next  = row_reg + 1'b1;
                                base_next = ADDR_W'(base_reg + COLS);
                                emit      = 1'b1;
                            end
                        end
                        OP_BS: begin
                            if (col_reg != '0) begin
                                col_next  = col_reg - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(base_reg + col_reg - 1'b1);
                                mem_wdata = {q_data.attr, CH_BLANK};
                            end
                            emit = 1'b1;
                        end
                        OP_CHAR: begin
                            mem_wdata = {q_data.attr, q_data.ch};
                            if (col_reg == COL_WRAP) begin
                                if (row_reg == LAST_ROW) begin
                                    col_next      = '0;
                                    cnt_next      = '0;
                                    fill_val_next = {q_data.attr, CH_BLANK};
                                    state_next    = S_SCR_RD;
                                end else begin
                                    row_next  = row_reg + 1'b1;
                                    base_next = ADDR_W'(base_reg + COLS);
                                    mem_we    = 1'b1;
                                    mem_waddr = ADDR_W'(base_reg + COLS);
                                    col_next  = COL_W'(1);
                                    emit      = 1'b1;
                                end
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(base_reg + col_reg);
                                col_next  = col_reg + 1'b1;
                                emit      = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            cnt_next      = '0;
                            fill_val_next = CLEAR_CELL;
                            state_next    = S_FILL;
                        end
                        OP_READ: begin
                            if (in_range) begin
                                mem_raddr  = ADDR_W'(q_data.idx);
                                state_next = S_READ;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                emit       = 1'b1;
                emit_data  = rd_data_reg;
                state_next = S_IDLE;
            end
            S_SCR_RD: begin
                state_next = S_SCR_WR;
            end
            S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                if (cnt_reg == LAST_COPY) begin
                    cnt_next   = BOTTOM_BASE;
                    state_next = S_FILL;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_SCR_RD;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    state_next = S_IDLE;
                    if (init_reg || cur_reg.kind == OP_CLEAR) begin
                        row_next  = '0;
                        col_next  = '0;
                        base_next = '0;
                        init_next = 1'b0;
                        emit      = !init_reg;
                    end else if (cur_reg.kind == OP_CHAR) begin
                        state_next = S_POST;
                    end else begin
                        emit = 1'b1;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_POST: begin
                mem_we     = 1'b1;
                mem_waddr  = base_reg;
                mem_wdata  = {cur_reg.attr, cur_reg.ch};
                col_next   = COL_W'(1);
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !m_tready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_row_next   = OUT_ROW_W'(row_next);
            out_col_next   = OUT_COL_W'(col_next);
            out_data_next  = emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FILL;
            cnt_reg       <= '0;
            fill_val_reg  <= CLEAR_CELL;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_val_reg  <= fill_val_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
        cur_reg      <= cur_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/text_mode_terminal_writer_core.sv */
`default_nettype none
// Character terminal over a ROWS x COLS store of 16-bit cells (attribute in the
// high byte, character in the low byte). Each request gives exactly one result
// with the cursor after it and, for a read, the cell. A front stage decodes
// requests into a two-entry queue; the back stage owns the cell memory, which
// has one write and one registered read port. CR, LF without scroll, backspace,
// a character, a no-op and a read outside the store are handled in the idle
// state of the back stage; a read of a cell in the store also passes through
// S_READ. A scroll copies every cell one row up, reading it in S_SCR_RD and
// writing it in S_SCR_WR, and then blanks the bottom row in S_FILL; a character
// that wraps off the last row is then written in S_POST. A clear writes every
// cell once in S_FILL. After reset the store is filled with blanks in S_FILL,
// during which s_tready stays low.
`include "text_mode_terminal_writer_core_macros.svh"
module text_mode_terminal_writer_core
    import tmtw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // ch[7:0], attr[15:8], cell_index[26:16]
    input  wire logic [1:0]  s_tuser,  // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata   // cursor_row[4:0], cursor_col[11:5],
                                       // cell_data[27:12]
);

    logic         push;
    op_t          push_op;
    op_t          head_op;
    q_status_t    q_stat;
    back_status_t back_stat;

    tmtw_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .back_stat (back_stat),
        .push      (push),
        .op        (push_op)
    );

    tmtw_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_op),
        .pop       (back_stat.pop),
        .pop_data  (head_op),
        .q_stat    (q_stat)
    );

    tmtw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_data    (head_op),
        .q_stat    (q_stat),
        .back_stat (back_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `TMTW_ASSERT_EXCL(a_no_push_full, push, q_stat.full, "request pushed into a full queue")
    `TMTW_ASSERT_EXCL(a_no_pop_empty, back_stat.pop, q_stat.empty, "pop from an empty queue")
    `TMTW_ASSERT_EXCL(a_no_result_init, back_stat.init_busy, m_tvalid, "result during fill")

endmodule
`default_nettype wire
